@@ rtl/core/button_debounce_long_press_core_defines.svh @@
// Assertion macros used by the merging stage of the debouncer.
`ifndef BUTTON_DEBOUNCE_LONG_PRESS_CORE_DEFINES_SVH
`define BUTTON_DEBOUNCE_LONG_PRESS_CORE_DEFINES_SVH

// The consequent must hold in the same cycle as the antecedent.
`define BDLP_ASSERT_SAME(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define BDLP_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

@@ rtl/core/bdlp_pkg.sv @@
// Shared types, constants and codes of the button debouncer.
package bdlp_pkg;

  localparam int DEF_BUTTONS = 5;
  localparam int TOUCH_W     = 5;
  localparam int TIME_W      = 48;
  localparam int MS_W        = 16;
  localparam int IDX_W       = 3;
  localparam int KIND_W      = 2;
  localparam int CNT_W       = 4;
  localparam int DIFF_W      = 26;
  localparam int CFG_IDX_W   = 1;
  localparam int CFG_W       = 16;
  localparam int RECIP_W     = 24;
  localparam int PROD_W      = 47;
  localparam int RECIP_SHIFT = 30;

  // Event kinds.
  localparam logic [KIND_W-1:0] KIND_PRESS   = 2'd0;
  localparam logic [KIND_W-1:0] KIND_RELEASE = 2'd1;
  localparam logic [KIND_W-1:0] KIND_LONG    = 2'd2;

  // Configuration register indexes.
  localparam logic [CFG_IDX_W-1:0] CFG_LONG_HOLD = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_DEBOUNCE  = 1'b1;

  localparam logic [MS_W-1:0]   DEF_LONG_MS   = 16'd1500;
  localparam logic [CNT_W-1:0]  DEF_DEBOUNCE  = 4'd2;
  localparam logic [CNT_W-1:0]  CNT_MAX       = 4'd15;
  localparam logic [9:0]        US_PER_MS     = 10'd1000;
  localparam logic [DIFF_W-1:0] DEF_LONG_US   = 26'd1500000;
  localparam logic [MS_W-1:0]   MS_SAT        = 16'hFFFF;
  // Smallest elapsed time whose millisecond count no longer fits 16 bits.
  localparam logic [TIME_W-1:0] SAT_US        = 48'd65536000;
  // ceil(2^30 / 125): exact quotient by 125 for operands below 2^23.
  localparam logic [RECIP_W-1:0] RECIP_125    = 24'd8589935;

  typedef struct packed {
    logic [TOUCH_W-1:0] touched_levels;
    logic [TIME_W-1:0]  time_us;
  } in_item_t;

  typedef struct packed {
    logic              has_event;
    logic [IDX_W-1:0]  button_index;
    logic [KIND_W-1:0] event_kind;
    logic [MS_W-1:0]   held_time_ms;
    logic [TOUCH_W-1:0] held_buttons;
    logic              last_of_tick;
  } out_item_t;

  // Pipeline steering sent from the top level to every lane.
  typedef struct packed {
    logic in_fire;
    logic s1_adv;
  } lane_ctrl_t;

  // What one lane found for one tick, after the millisecond conversion.
  typedef struct packed {
    logic              ev;
    logic [KIND_W-1:0] kind;
    logic [MS_W-1:0]   ms;
    logic              held;
  } lane_ev_t;

endpackage

@@ rtl/core/bdlp_lane.sv @@
// One button lane: debounce state, event detection and millisecond conversion.
module bdlp_lane (
  input  logic                          clk,
  input  logic                          rst,
  input  bdlp_pkg::lane_ctrl_t          ctrl,
  input  logic                          touched,
  input  logic [bdlp_pkg::TIME_W-1:0]   now,
  input  logic [bdlp_pkg::DIFF_W-1:0]   thresh_us,
  input  logic [bdlp_pkg::CNT_W-1:0]    debounce,
  output bdlp_pkg::lane_ev_t            ev
);

  logic                          settled, settled_next;
  logic                          pending, pending_next;
  logic [bdlp_pkg::CNT_W-1:0]    cnt, cnt_next, cnt_inc;
  logic [bdlp_pkg::TIME_W-1:0]   start, start_next;
  logic                          long_rep, long_next;
  logic                          raw;
  logic [bdlp_pkg::TIME_W-1:0]   diff;
  logic                          ev_hit, ev_press;
  logic [bdlp_pkg::KIND_W-1:0]   ev_kind;

  logic                          s1_ev, s1_sat, s1_held;
  logic [bdlp_pkg::KIND_W-1:0]   s1_kind;
  logic [bdlp_pkg::DIFF_W-1:0]   s1_diff;
  logic [bdlp_pkg::PROD_W-1:0]   prod;
  logic [bdlp_pkg::MS_W-1:0]     ms_conv;

  // Debounce step and event detection for the sample of this tick.
  always_comb begin
    raw          = ~touched;
    cnt_inc      = (cnt == bdlp_pkg::CNT_MAX) ? bdlp_pkg::CNT_MAX : cnt + 4'd1;
    diff         = now - start;
    settled_next = settled;
    pending_next = pending;
    cnt_next     = cnt;
    start_next   = start;
    long_next    = long_rep;
    ev_hit       = 1'b0;
    ev_press     = 1'b0;
    ev_kind      = bdlp_pkg::KIND_PRESS;
    if (raw == settled) begin
      cnt_next = '0;
    end else if (raw == pending) begin
      if (cnt_inc >= debounce) begin
        settled_next = raw;
        cnt_next     = '0;
        ev_hit       = 1'b1;
        if (!raw) begin
          start_next = now;
          long_next  = 1'b0;
          ev_press   = 1'b1;
          ev_kind    = bdlp_pkg::KIND_PRESS;
        end else begin
          ev_kind = bdlp_pkg::KIND_RELEASE;
        end
      end else begin
        cnt_next = cnt_inc;
      end
    end else begin
      pending_next = raw;
      cnt_next     = 4'd1;
    end
    // A press on this tick has zero held time, so it cannot also be long.
    if (!settled_next && !long_next && !ev_press &&
        (diff >= bdlp_pkg::TIME_W'(thresh_us))) begin
      long_next = 1'b1;
      ev_hit    = 1'b1;
      ev_kind   = bdlp_pkg::KIND_LONG;
    end
  end

  // Button state, updated on every input transfer.
  always_ff @(posedge clk) begin
    if (rst) begin
      settled  <= 1'b1;
      pending  <= 1'b0;
      cnt      <= '0;
      long_rep <= 1'b0;
    end else if (ctrl.in_fire) begin
      settled  <= settled_next;
      pending  <= pending_next;
      cnt      <= cnt_next;
      long_rep <= long_next;
    end
  end

  always_ff @(posedge clk) begin
    if (ctrl.in_fire) begin
      start <= start_next;
    end
  end

  // First stage: the event and its raw elapsed time.
  always_ff @(posedge clk) begin
    if (ctrl.in_fire) begin
      s1_ev   <= ev_hit;
      s1_kind <= ev_kind;
      s1_held <= ~settled_next;
      s1_sat  <= !ev_press && (diff >= bdlp_pkg::SAT_US);
      s1_diff <= ev_press ? '0 : diff[bdlp_pkg::DIFF_W-1:0];
    end
  end

  // Divide by 1000 as a shift by three and a reciprocal multiply by 1/125.
  always_comb begin
    prod    = bdlp_pkg::PROD_W'(s1_diff[bdlp_pkg::DIFF_W-1:3]) *
              bdlp_pkg::PROD_W'(bdlp_pkg::RECIP_125);
    ms_conv = s1_sat ? bdlp_pkg::MS_SAT : prod[bdlp_pkg::RECIP_SHIFT +: bdlp_pkg::MS_W];
  end

  // Second stage: the event with its held time in milliseconds.
  always_ff @(posedge clk) begin
    if (ctrl.s1_adv) begin
      ev.ev   <= s1_ev;
      ev.kind <= s1_kind;
      ev.ms   <= ms_conv;
      ev.held <= s1_held;
    end
  end

endmodule

@@ rtl/core/bdlp_merge.sv @@
// Merging stage: collects the lane events of one tick and sends them out in button order.
`include "button_debounce_long_press_core_defines.svh"

module bdlp_merge #(
  parameter int BUTTONS = bdlp_pkg::DEF_BUTTONS
) (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              load_valid,
  output logic                              load_ready,
  input  bdlp_pkg::lane_ev_t [BUTTONS-1:0]  lanes,
  output logic                              out_valid,
  input  logic                              out_ready,
  output bdlp_pkg::out_item_t               out_data
);

  logic                              mb_valid;
  logic [BUTTONS-1:0]                pend;
  logic [bdlp_pkg::KIND_W-1:0]       kind [BUTTONS];
  logic [bdlp_pkg::MS_W-1:0]         ms   [BUTTONS];
  logic [bdlp_pkg::TOUCH_W-1:0]      mask, mask_next;
  logic [BUTTONS-1:0]                lanes_ev, low;
  logic                              last, load, out_xfer;
  logic [bdlp_pkg::IDX_W-1:0]        sel_idx;
  logic [bdlp_pkg::KIND_W-1:0]       sel_kind;
  logic [bdlp_pkg::MS_W-1:0]         sel_ms;

  // Event flags and held mask gathered from the lanes.
  always_comb begin
    mask_next = '0;
    for (int i = 0; i < BUTTONS; i++) begin
      lanes_ev[i] = lanes[i].ev;
      if (i < bdlp_pkg::TOUCH_W) begin
        mask_next[i] = lanes[i].held;
      end
    end
  end

  // Lowest pending button goes out first.
  always_comb begin
    low      = pend & (~pend + BUTTONS'(1));
    last     = ((pend & (pend - BUTTONS'(1))) == '0);
    sel_idx  = '0;
    sel_kind = bdlp_pkg::KIND_PRESS;
    sel_ms   = '0;
    for (int i = BUTTONS - 1; i >= 0; i--) begin
      if (pend[i]) begin
        sel_idx  = bdlp_pkg::IDX_W'(i);
        sel_kind = kind[i];
        sel_ms   = ms[i];
      end
    end
  end

  assign out_valid  = mb_valid;
  assign out_xfer   = mb_valid && out_ready;
  assign load_ready = !mb_valid || (out_ready && last);
  assign load       = load_valid && load_ready;

  always_comb begin
    out_data.has_event    = |pend;
    out_data.button_index = sel_idx;
    out_data.event_kind   = sel_kind;
    out_data.held_time_ms = sel_ms;
    out_data.held_buttons = mask;
    out_data.last_of_tick = last;
  end

  // Buffer control: a tick stays until its final result is transferred.
  always_ff @(posedge clk) begin
    if (rst) begin
      mb_valid <= 1'b0;
      pend     <= '0;
    end else if (load) begin
      mb_valid <= 1'b1;
      pend     <= lanes_ev;
    end else if (out_xfer) begin
      if (last) begin
        mb_valid <= 1'b0;
      end
      pend <= pend & ~low;
    end
  end

  // Event payload of the buffered tick.
  always_ff @(posedge clk) begin
    if (load) begin
      mask <= mask_next;
      for (int i = 0; i < BUTTONS; i++) begin
        kind[i] <= lanes[i].kind;
        ms[i]   <= lanes[i].ms;
      end
    end
  end

  `BDLP_ASSERT_SAME(a_mid_has_event, out_valid && !out_data.last_of_tick, out_data.has_event, "result before the last of a tick carries no event")
  `BDLP_ASSERT_NEXT(a_mid_keeps_tick, out_xfer && !last, out_valid && $stable(mask), "tick dropped or mask changed before its last result")
  `BDLP_ASSERT_SAME(a_index_range, out_valid && out_data.has_event, 32'(out_data.button_index) < BUTTONS, "event names a button that does not exist")
  `BDLP_ASSERT_SAME(a_one_pick, out_valid && out_data.has_event, $onehot(low), "more than one event selected")

endmodule

@@ rtl/core/button_debounce_long_press_core.sv @@
// Path: the first result of a tick is offered once its input transfer has passed the lane,
//   convert and merge registers; each of them can hold while the stage after it is not free.
// Throughput: a tick with k events (k from 0 to BUTTONS) gives max(k, 1) output results;
//   a new input is taken each cycle while the merge buffer can drain, set by the single
//   result port of the merging stage.
// Reset: synchronous and active high; all buttons idle, threshold 1500 ms, debounce of 2.
module button_debounce_long_press_core #(
  parameter int BUTTONS = bdlp_pkg::DEF_BUTTONS
) (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            in_valid,
  output logic                            in_ready,
  input  bdlp_pkg::in_item_t              in_data,
  output logic                            out_valid,
  input  logic                            out_ready,
  output bdlp_pkg::out_item_t             out_data,
  input  logic                            cfg_we,
  input  logic [bdlp_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [bdlp_pkg::CFG_W-1:0]      cfg_wdata
);

  logic [bdlp_pkg::DIFF_W-1:0]       thresh_us;
  logic [bdlp_pkg::CNT_W-1:0]        debounce;
  logic [bdlp_pkg::MS_W-1:0]         thresh_ms_sel;
  logic                              s1_valid, s2_valid;
  logic                              s1_adv, s2_adv, mb_ready;
  bdlp_pkg::lane_ctrl_t              ctrl;
  bdlp_pkg::lane_ev_t [BUTTONS-1:0]  lanes;

  // Configuration: the threshold is kept in microseconds, zero selecting the default.
  assign thresh_ms_sel = (cfg_wdata == '0) ? bdlp_pkg::DEF_LONG_MS : cfg_wdata;

  always_ff @(posedge clk) begin
    if (rst) begin
      thresh_us <= bdlp_pkg::DEF_LONG_US;
      debounce  <= bdlp_pkg::DEF_DEBOUNCE;
    end else if (cfg_we) begin
      unique case (cfg_index)
        bdlp_pkg::CFG_LONG_HOLD: begin
          thresh_us <= bdlp_pkg::DIFF_W'(thresh_ms_sel) *
                       bdlp_pkg::DIFF_W'(bdlp_pkg::US_PER_MS);
        end
        bdlp_pkg::CFG_DEBOUNCE: begin
          debounce <= cfg_wdata[bdlp_pkg::CNT_W-1:0];
        end
        default: begin
        end
      endcase
    end
  end

  // Pipeline steering: each stage moves on when the next one is free or moving.
  assign s2_adv       = s2_valid && mb_ready;
  assign s1_adv       = s1_valid && (!s2_valid || s2_adv);
  assign in_ready     = !s1_valid || s1_adv;
  assign ctrl.in_fire = in_valid && in_ready;
  assign ctrl.s1_adv  = s1_adv;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
      s2_valid <= 1'b0;
    end else begin
      if (ctrl.in_fire) begin
        s1_valid <= 1'b1;
      end else if (s1_adv) begin
        s1_valid <= 1'b0;
      end
      if (s1_adv) begin
        s2_valid <= 1'b1;
      end else if (s2_adv) begin
        s2_valid <= 1'b0;
      end
    end
  end

  // One lane per button; buttons without a touch input never see a press.
  for (genvar i = 0; i < BUTTONS; i++) begin : g_lane
    logic touched;
    if (i < bdlp_pkg::TOUCH_W) begin : g_wired
      assign touched = in_data.touched_levels[i];
    end else begin : g_unwired
      assign touched = 1'b0;
    end

    bdlp_lane u_lane (
      .clk       (clk),
      .rst       (rst),
      .ctrl      (ctrl),
      .touched   (touched),
      .now       (in_data.time_us),
      .thresh_us (thresh_us),
      .debounce  (debounce),
      .ev        (lanes[i])
    );
  end

  bdlp_merge #(
    .BUTTONS (BUTTONS)
  ) u_merge (
    .clk        (clk),
    .rst        (rst),
    .load_valid (s2_valid),
    .load_ready (mb_ready),
    .lanes      (lanes),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .out_data   (out_data)
  );

endmodule
